// ----- sv/bskh64_pkg.sv -----
// Package for the byte stream key hash unit.
// Holds the seed and mix constants and the per-byte absorb function.
// No dependencies.
`default_nettype none

package bskh64_pkg;

  localparam logic [63:0] SEED_VALUE = 64'h1234_5678_9ABC_DEF0;
  localparam logic [63:0] MIX_VALUE  = 64'h5A5A_5A5A_5A5A_5A5A;

  typedef logic [63:0] key_t;
  typedef logic [5:0]  index_t;

  function automatic key_t absorb(input key_t acc_in, input logic [7:0] b,
                                  input index_t pos);
    key_t        acc;
    key_t        bw;
    logic [14:0] bs;
    bw  = {56'd0, b};
    bs  = {7'd0, b} << pos[2:0];
    acc = acc_in ^ bw;
    acc = {acc[56:0], acc[63:57]};
    acc = acc + {49'd0, bs};
    acc = ~{acc[52:0], acc[63:53]};
    acc = acc ^ MIX_VALUE;
    acc = {acc[60:0], acc[63:61]};
    acc = acc + bw;
    acc = acc ^ bw ^ (acc >> pos);
    return acc;
  endfunction

endpackage

`default_nettype wire

// ----- sv/byte_stream_key_hash64_unit.sv -----
// Top level of the byte stream key hash unit.
// Depends on bskh64_pkg for constants and the absorb function.
//
// Usage:
//   Input words arrive on the s_axis group: tdata carries the message byte,
//   tuser flags whether the byte is present, tlast ends the message.
//   A word with tuser low and tlast high closes an empty message.
//   The m_axis group carries one 64-bit key per finished message.
// Timing:
//   One input word is taken every cycle while s_axis_tready is high. The key
//   of a message appears on m_axis in the cycle after its tlast word is accepted.
//   The whole absorb chain for a byte (rotates, two 64-bit adds and a
//   variable right shift) sits between the key register and itself.
// Reset:
//   rst returns the running key to the seed, the byte index to zero and
//   drops m_axis_tvalid.
// Stall:
//   While a key waits on m_axis and m_axis_tready is low, s_axis_tready is
//   low. When the key is taken, a new word is accepted in the same cycle.
`default_nettype none

module byte_stream_key_hash64_unit
  import bskh64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // last_item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [63:0] key_out
);

  key_t   running_key;
  key_t   running_key_next;
  index_t byte_index;
  index_t byte_index_next;
  key_t   mixed_key;
  logic   take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign mixed_key     = s_axis_tuser ? absorb(running_key, s_axis_tdata, byte_index)
                                      : running_key;

  always_comb begin
    running_key_next = running_key;
    byte_index_next  = byte_index;
    if (take) begin
      if (s_axis_tlast) begin
        running_key_next = SEED_VALUE;
        byte_index_next  = '0;
      end else begin
        running_key_next = mixed_key;
        byte_index_next  = s_axis_tuser ? byte_index + 6'd1 : byte_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_key   <= SEED_VALUE;
      byte_index    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      running_key <= running_key_next;
      byte_index  <= byte_index_next;
      if (take && s_axis_tlast) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_axis_tlast) begin
      m_axis_tdata <= mixed_key;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && byte_index == 6'd0 && running_key == SEED_VALUE))
    else $error("reset did not clear state");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (take && s_axis_tlast) |=> (m_axis_tvalid && running_key == SEED_VALUE
                                && byte_index == 6'd0))
    else $error("end of message did not emit key and restart");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    (take && s_axis_tuser && !s_axis_tlast) |=> (byte_index == $past(byte_index) + 6'd1))
    else $error("byte index did not advance");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !s_axis_tuser && !s_axis_tlast) |=> $stable(running_key))
    else $error("idle word changed the key");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while key stalled");

endmodule

`default_nettype wire
